/* design/bsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants, register indexes and helper functions for the barometric
// sensor compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // oversampling setting of the sensor (0 to 3)
    localparam int unsigned OVERSAMPLING = 3;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_W  = 48;
    localparam int unsigned UT_W   = 16;
    localparam int unsigned RP_W   = 24;

    // compensation constants
    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] B4_BIAS    = 32'd32768;
    localparam logic [31:0] B7_BASE    = 32'd50000;
    localparam logic [31:0] P_SQ_COEF  = 32'd3038;
    localparam logic [31:0] P_LIN_COEF = 32'd7357;
    localparam logic [31:0] P_OFFSET   = 32'd3791;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_GROUP_A = 2'd0,
        CFG_GROUP_B = 2'd1,
        CFG_GROUP_C = 2'd2,
        CFG_GROUP_D = 2'd3
    } t_cfg_idx;

    // arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
        logic signed [31:0] s;
        s = $signed(v);
        return $unsigned(s >>> n);
    endfunction

    // sign-extend a 16-bit coefficient
    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

/* design/bsc_udiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_udiv
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband word that travels alongside. Whole pipe advances on i_en.
// ----------------------------------------------------------------------------
module bsc_udiv #(
    parameter int unsigned W  = 32,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_quo,
    output logic [SW-1:0] o_side
);

    logic [W-1:0]  r_vld;
    logic [W-1:0]  r_rem  [W];
    logic [W-1:0]  r_num  [W];
    logic [W-1:0]  r_den  [W];
    logic [W-1:0]  r_quo  [W];
    logic [SW-1:0] r_side [W];

    logic [W-1:0]  n_rem  [W];
    logic [W-1:0]  n_num  [W];
    logic [W-1:0]  n_quo  [W];

    // one trial subtraction per stage
    always_comb begin
        logic [W:0]   v_trial;
        logic [W-1:0] v_rem;
        logic [W-1:0] v_num;
        logic [W-1:0] v_den;
        logic [W-1:0] v_quo;
        logic         v_ge;
        for (int k = 0; k < W; k++) begin
            if (k == 0) begin
                v_rem = '0;
                v_num = i_num;
                v_den = i_den;
                v_quo = '0;
            end else begin
                v_rem = r_rem[k-1];
                v_num = r_num[k-1];
                v_den = r_den[k-1];
                v_quo = r_quo[k-1];
            end
            v_trial  = {v_rem, v_num[W-1]};
            v_ge     = (v_trial >= {1'b0, v_den});
            n_rem[k] = v_ge ? W'(v_trial - {1'b0, v_den}) : v_trial[W-1:0];
            n_num[k] = {v_num[W-2:0], 1'b0};
            n_quo[k] = {v_quo[W-2:0], v_ge};
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[W-2:0], i_valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
                r_quo[k] <= n_quo[k];
                if (k == 0) begin
                    r_den[k]  <= i_den;
                    r_side[k] <= i_side;
                end else begin
                    r_den[k]  <= r_den[k-1];
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_quo   = r_quo[W-1];
    assign o_side  = r_side[W-1];

endmodule

/* design/barometric_sensor_compensation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer temperature and pressure compensation for a barometric sensor,
// fully pipelined with two bit-per-stage dividers.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one item: raw temperature (bits 15:0) and raw 24-bit
//   pressure (bits 39:16). Master stream gives one item per input: tdata holds
//   temperature in tenths of a degree (31:0) and pressure in Pa (63:32);
//   tuser is the divide fault flag, with both results zero when it is set.
//   Calibration goes in through the cfg channel (index 0..3), always ready;
//   write it only while the pipe is empty.
//   The pipe holds 13 register stages of arithmetic plus two 32-stage
//   dividers, each taking one quotient bit per stage.
//   Throughput is one item per cycle while the receiver does not stall.
//   Reset clears calibration and all valid bits; data registers are not reset.
//   When the receiver stalls a full output register, the whole pipe freezes
//   and o_s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation #(
    parameter int unsigned OVERSAMPLING = bsc_pkg::OVERSAMPLING
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // raw_temperature[15:0], raw_pressure[39:16]
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // temperature_tenths[31:0], pressure_pa[63:32]
    output logic        o_m_axis_tuser,   // div_fault[0]
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    localparam int unsigned OS = OVERSAMPLING;
    localparam logic [31:0] B7_SCALE = bsc_pkg::B7_BASE >> OS;

    // calibration registers
    logic [47:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c, r_cal_d;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
            r_cal_d <= '0;
        end else if (i_cfg_valid) begin
            unique case (bsc_pkg::t_cfg_idx'(i_cfg_index))
                bsc_pkg::CFG_GROUP_A: r_cal_a <= i_cfg_data;
                bsc_pkg::CFG_GROUP_B: r_cal_b <= i_cfg_data;
                bsc_pkg::CFG_GROUP_C: r_cal_c <= i_cfg_data[31:0];
                bsc_pkg::CFG_GROUP_D: r_cal_d <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = bsc_pkg::sx16(r_cal_a[15:0]);
    assign ac2 = bsc_pkg::sx16(r_cal_a[31:16]);
    assign ac3 = bsc_pkg::sx16(r_cal_a[47:32]);
    assign ac4 = {16'd0, r_cal_b[15:0]};
    assign ac5 = {16'd0, r_cal_b[31:16]};
    assign ac6 = {16'd0, r_cal_b[47:32]};
    assign b1  = bsc_pkg::sx16(r_cal_c[15:0]);
    assign b2  = bsc_pkg::sx16(r_cal_c[31:16]);
    assign mc  = bsc_pkg::sx16(r_cal_d[15:0]);
    assign md  = bsc_pkg::sx16(r_cal_d[31:16]);

    // global advance: the pipe moves unless a finished item is held
    logic en;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stage 1: raw unpack, (UT - AC6) * AC5
    logic        r_v1;
    logic [31:0] r1_prod;
    logic [23:0] r1_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_v1 <= 1'b0;
        else if (en)   r_v1 <= i_s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod <= ({16'd0, i_s_axis_tdata[15:0]} - ac6) * ac5;
            r1_up   <= i_s_axis_tdata[39:16] >> (8 - OS);
        end
    end

    // stage 2: X1, divisor magnitude and sign of the quotient
    logic [31:0] s2_x1, s2_div, s2_num;
    assign s2_x1  = bsc_pkg::asr32(r1_prod, 15);
    assign s2_div = s2_x1 + md;
    assign s2_num = {mc[20:0], 11'd0};

    logic        r_v2, r2_zero, r2_neg;
    logic [31:0] r2_x1, r2_den, r2_num;
    logic [23:0] r2_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_v2 <= 1'b0;
        else if (en)   r_v2 <= r_v1;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_x1   <= s2_x1;
            r2_up   <= r1_up;
            r2_zero <= (s2_div == '0);
            r2_neg  <= s2_div[31] ^ s2_num[31];
            r2_den  <= s2_div[31] ? (32'd0 - s2_div) : s2_div;
            r2_num  <= s2_num[31] ? (32'd0 - s2_num) : s2_num;
        end
    end

    // temperature divider
    localparam int unsigned SW1 = 32 + 24 + 2;
    logic           d1_v;
    logic [31:0]    d1_q;
    logic [SW1-1:0] d1_side;
    bsc_udiv #(.W(32), .SW(SW1)) u_div_t (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_v2),
        .i_num  (r2_num),
        .i_den  (r2_den),
        .i_side ({r2_x1, r2_up, r2_zero, r2_neg}),
        .o_valid(d1_v),
        .o_quo  (d1_q),
        .o_side (d1_side)
    );

    // stage 3: B5 and B6
    logic [31:0] s3_x1, s3_x2, s3_b5;
    assign s3_x1 = d1_side[57:26];
    assign s3_x2 = d1_side[0] ? (32'd0 - d1_q) : d1_q;
    assign s3_b5 = s3_x1 + s3_x2;

    logic        r_v3, r3_z;
    logic [31:0] r3_b5, r3_b6;
    logic [23:0] r3_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_v3 <= 1'b0;
        else if (en)   r_v3 <= d1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_b5 <= s3_b5;
            r3_b6 <= s3_b5 - bsc_pkg::B6_OFFSET;
            r3_up <= d1_side[25:2];
            r3_z  <= d1_side[1];
        end
    end

    // stage 4: B6 squared, AC2 * B6, AC3 * B6
    logic        r_v4, r4_z;
    logic [31:0] r4_sq, r4_p2, r4_p3, r4_b5;
    logic [23:0] r4_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_v4 <= 1'b0;
        else if (en)   r_v4 <= r_v3;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sq <= r3_b6 * r3_b6;
            r4_p2 <= ac2 * r3_b6;
            r4_p3 <= ac3 * r3_b6;
            r4_b5 <= r3_b5;
            r4_up <= r3_up;
            r4_z  <= r3_z;
        end
    end

    // stage 5: scale the square
    logic        r_v5, r5_z;
    logic [31:0] r5_sq, r5_p2, r5_p3, r5_b5;
    logic [23:0] r5_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_v5 <= 1'b0;
        else if (en)   r_v5 <= r_v4;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_sq <= bsc_pkg::asr32(r4_sq, 12);
            r5_p2 <= r4_p2;
            r5_p3 <= r4_p3;
            r5_b5 <= r4_b5;
            r5_up <= r4_up;
            r5_z  <= r4_z;
        end
    end

    // stage 6: B2 * sq, B1 * sq
    logic        r_v6, r6_z;
    logic [31:0] r6_m2, r6_m1, r6_p2, r6_p3, r6_b5;
    logic [23:0] r6_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_v6 <= 1'b0;
        else if (en)   r_v6 <= r_v5;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_m2 <= b2 * r5_sq;
            r6_m1 <= b1 * r5_sq;
            r6_p2 <= r5_p2;
            r6_p3 <= r5_p3;
            r6_b5 <= r5_b5;
            r6_up <= r5_up;
            r6_z  <= r5_z;
        end
    end

    // stage 7: B3 and the X3 term of B4
    logic [31:0] s7_x3a, s7_b3, s7_x3b;
    assign s7_x3a = bsc_pkg::asr32(r6_m2, 11) + bsc_pkg::asr32(r6_p2, 11);
    assign s7_b3  = bsc_pkg::asr32((((ac1 << 2) + s7_x3a) << OS) + 32'd2, 2);
    assign s7_x3b = bsc_pkg::asr32(bsc_pkg::asr32(r6_p3, 13)
                                   + bsc_pkg::asr32(r6_m1, 16) + 32'd2, 2);

    logic        r_v7, r7_z;
    logic [31:0] r7_b3, r7_x3, r7_b5;
    logic [23:0] r7_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_v7 <= 1'b0;
        else if (en)   r_v7 <= r_v6;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_b3 <= s7_b3;
            r7_x3 <= s7_x3b;
            r7_b5 <= r6_b5;
            r7_up <= r6_up;
            r7_z  <= r6_z;
        end
    end

    // stage 8: B4 product and B7
    logic        r_v8, r8_z;
    logic [31:0] r8_b4p, r8_b7, r8_b5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_v8 <= 1'b0;
        else if (en)   r_v8 <= r_v7;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_b4p <= ac4 * (r7_x3 + bsc_pkg::B4_BIAS);
            r8_b7  <= ({8'd0, r7_up} - r7_b3) * B7_SCALE;
            r8_b5  <= r7_b5;
            r8_z   <= r7_z;
        end
    end

    // stage 9: divider operands for the pressure quotient
    logic [31:0] s9_b4;
    assign s9_b4 = r8_b4p >> 15;

    logic        r_v9, r9_z, r9_big;
    logic [31:0] r9_num, r9_den, r9_b5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_v9 <= 1'b0;
        else if (en)   r_v9 <= r_v8;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_den <= s9_b4;
            r9_z   <= r8_z || (s9_b4 == '0);
            r9_big <= r8_b7[31];
            r9_num <= r8_b7[31] ? r8_b7 : {r8_b7[30:0], 1'b0};
            r9_b5  <= r8_b5;
        end
    end

    // pressure divider
    localparam int unsigned SW2 = 32 + 2;
    logic           d2_v;
    logic [31:0]    d2_q;
    logic [SW2-1:0] d2_side;
    bsc_udiv #(.W(32), .SW(SW2)) u_div_p (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_v9),
        .i_num  (r9_num),
        .i_den  (r9_den),
        .i_side ({r9_b5, r9_z, r9_big}),
        .o_valid(d2_v),
        .o_quo  (d2_q),
        .o_side (d2_side)
    );

    // stage 10: undo the large-B7 scaling
    logic        r_v10, r10_z;
    logic [31:0] r10_pu, r10_b5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_v10 <= 1'b0;
        else if (en)   r_v10 <= d2_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_pu <= d2_side[0] ? {d2_q[30:0], 1'b0} : d2_q;
            r10_b5 <= d2_side[33:2];
            r10_z  <= d2_side[1];
        end
    end

    // stage 11: (p >> 8)^2 and -7357 * p
    logic [31:0] s11_tmp;
    assign s11_tmp = bsc_pkg::asr32(r10_pu, 8);

    logic        r_v11, r11_z;
    logic [31:0] r11_t2, r11_m7, r11_pu, r11_b5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_v11 <= 1'b0;
        else if (en)   r_v11 <= r_v10;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_t2 <= s11_tmp * s11_tmp;
            r11_m7 <= 32'd0 - (bsc_pkg::P_LIN_COEF * r10_pu);
            r11_pu <= r10_pu;
            r11_b5 <= r10_b5;
            r11_z  <= r10_z;
        end
    end

    // stage 12: 3038 * square
    logic        r_v12, r12_z;
    logic [31:0] r12_m3, r12_m7, r12_pu, r12_b5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_v12 <= 1'b0;
        else if (en)   r_v12 <= r_v11;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_m3 <= r11_t2 * bsc_pkg::P_SQ_COEF;
            r12_m7 <= r11_m7;
            r12_pu <= r11_pu;
            r12_b5 <= r11_b5;
            r12_z  <= r11_z;
        end
    end

    // output stage: final correction (divide by 16 toward zero) and results
    logic [31:0] s13_sum, s13_corr, s13_p, s13_t;
    assign s13_sum  = bsc_pkg::asr32(r12_m3, 16) + bsc_pkg::asr32(r12_m7, 16)
                      + bsc_pkg::P_OFFSET;
    assign s13_corr = bsc_pkg::asr32(s13_sum + (s13_sum[31] ? 32'd15 : 32'd0), 4);
    assign s13_p    = r12_pu + s13_corr;
    assign s13_t    = bsc_pkg::asr32(r12_b5 + 32'd8, 4);

    logic        r_vo;
    logic [63:0] r_odata;
    logic        r_ofault;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_vo <= 1'b0;
        else if (en)   r_vo <= r_v12;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_odata  <= r12_z ? 64'd0 : {s13_p, s13_t};
            r_ofault <= r12_z;
        end
    end

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ofault;

endmodule

/* design/bsc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks on the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module bsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // a held item stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output item dropped while stalled");

    // a held item keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata)
        && $stable(o_m_axis_tuser))
        else $error("output item changed while stalled");

    // a stalled output freezes the pipe, so the input side must stall too
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input accepted while output stalled");

    // a divide fault gives zero results
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == 64'd0)
        else $error("fault item with non-zero results");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);

/* tb/barometric_sensor_compensation_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_tb
// Self-checking bench for the barometric compensation pipeline. Calibration
// sets (reset values, datasheet values, extremes, a zero pressure divisor,
// random sets) are loaded between phases while the pipe is empty. Each later
// phase streams directed and random reading pairs under one of four patterns
// of sender gaps and receiver stalls. An in-bench model predicts temperature,
// pressure and the divide fault flag for every accepted item, and the
// outputs are compared in order.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_tb;

    localparam int unsigned HALF_PERIOD = 4;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned PHASES = 9;
    localparam int unsigned RANDOM_PER_PHASE = 210;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [15:0] raw_temperature;
    } t_reading;

    typedef struct packed {
        logic [31:0] temperature_tenths;
        logic [31:0] pressure_pa;
        logic        div_fault;
    } t_compensated;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;   // raw_temperature[15:0], raw_pressure[39:16]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [63:0] o_m_axis_tdata;   // temperature_tenths[31:0], pressure_pa[63:32]
    logic        o_m_axis_tuser;   // div_fault[0]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [47:0] i_cfg_data;

    // calibration as the bench believes it
    logic [47:0] cal_a, cal_b;
    logic [31:0] cal_c, cal_d;

    t_reading     pending_readings[$];
    t_compensated expected_results[$];
    int unsigned  src_idle_pct;
    int unsigned  rx_stall_pct;
    int unsigned  error_count;
    int unsigned  cfg_writes;
    int unsigned  quiet_cycles;
    logic         reading_taken;

    barometric_sensor_compensation DUT (.*);

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // arithmetic shift right on a 32-bit word
    function automatic logic [31:0] sra32(input logic [31:0] v, input int n);
        logic signed [31:0] s;
        s = v;
        return s >>> n;
    endfunction

    function automatic logic [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // integer compensation of one reading pair with the current calibration
    function automatic t_compensated compensate(input t_reading rd);
        t_compensated r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, pu, sq, tmp;
        logic signed [31:0] num, den, quo, sum;
        ac1 = ext16(cal_a[15:0]);
        ac2 = ext16(cal_a[31:16]);
        ac3 = ext16(cal_a[47:32]);
        ac4 = {16'd0, cal_b[15:0]};
        ac5 = {16'd0, cal_b[31:16]};
        ac6 = {16'd0, cal_b[47:32]};
        b1  = ext16(cal_c[15:0]);
        b2  = ext16(cal_c[31:16]);
        mc  = ext16(cal_d[15:0]);
        md  = ext16(cal_d[31:16]);
        ut  = {16'd0, rd.raw_temperature};
        up  = {8'd0, rd.raw_pressure} >> (8 - bsc_pkg::OVERSAMPLING);
        r   = '{32'd0, 32'd0, 1'b1};
        // temperature
        x1  = sra32((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        num = mc << 11;
        quo = num / den;
        b5  = x1 + quo;
        // pressure
        b6  = b5 - 32'd4000;
        sq  = sra32(b6 * b6, 12);
        x1  = sra32(b2 * sq, 11);
        x2  = sra32(ac2 * b6, 11);
        x3  = x1 + x2;
        b3  = sra32(((ac1 * 32'd4 + x3) << bsc_pkg::OVERSAMPLING) + 32'd2, 2);
        x1  = sra32(ac3 * b6, 13);
        x2  = sra32(b1 * sq, 16);
        x3  = sra32(x1 + x2 + 32'd2, 2);
        b4  = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7  = (up - b3) * (32'd50000 >> bsc_pkg::OVERSAMPLING);
        if (b7 < 32'h8000_0000) pu = (b7 * 32'd2) / b4;
        else pu = (b7 / b4) * 32'd2;
        tmp = sra32(pu, 8);
        x1  = tmp * tmp;
        x1  = sra32(x1 * 32'd3038, 16);
        x2  = sra32(32'd0 - 32'd7357 * pu, 16);
        sum = x1 + x2 + 32'd3791;
        quo = sum / 32'sd16;
        r.pressure_pa        = pu + quo;
        r.temperature_tenths = sra32(b5 + 32'd8, 4);
        r.div_fault          = 1'b0;
        return r;
    endfunction

    // sender: next item or a gap, decided at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || reading_taken) begin
            if (pending_readings.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                i_s_axis_tdata  <= pending_readings.pop_front();
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        i_m_axis_tready <= i_rst_n && ($urandom_range(99) >= rx_stall_pct);
    end

    // input and calibration acceptance, prediction
    always @(posedge i_clk) begin
        reading_taken <= 1'b0;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            expected_results.push_back(compensate(i_s_axis_tdata));
            reading_taken <= 1'b1;
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (bsc_pkg::t_cfg_idx'(i_cfg_index))
                bsc_pkg::CFG_GROUP_A: cal_a = i_cfg_data;
                bsc_pkg::CFG_GROUP_B: cal_b = i_cfg_data;
                bsc_pkg::CFG_GROUP_C: cal_c = i_cfg_data[31:0];
                bsc_pkg::CFG_GROUP_D: cal_d = i_cfg_data[31:0];
            endcase
            cfg_writes <= cfg_writes + 1;
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_compensated want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b", $time,
                         o_m_axis_tdata, o_m_axis_tuser);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tdata[31:0] !== want.temperature_tenths) begin
                    $display("%0t: temperature expected %0d actual %0d", $time,
                             $signed(want.temperature_tenths),
                             $signed(o_m_axis_tdata[31:0]));
                    error_count++;
                end
                if (o_m_axis_tdata[63:32] !== want.pressure_pa) begin
                    $display("%0t: pressure expected %0d actual %0d", $time,
                             $signed(want.pressure_pa), $signed(o_m_axis_tdata[63:32]));
                    error_count++;
                end
                if (o_m_axis_tuser !== want.div_fault) begin
                    $display("%0t: div fault expected %b actual %b", $time,
                             want.div_fault, o_m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_cal(input bsc_pkg::t_cfg_idx idx, input logic [47:0] value);
        int unsigned seen;
        seen = cfg_writes;
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        wait (cfg_writes != seen);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_reading(input logic [15:0] ut, input logic [23:0] rp);
        pending_readings.push_back('{raw_pressure: rp, raw_temperature: ut});
    endtask

    task automatic wait_drained();
        wait (pending_readings.size() == 0 && expected_results.size() == 0
              && !i_s_axis_tvalid);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] edge_ut[5];
        logic [23:0] edge_rp[5];
        logic [47:0] ga, gb, gc, gd;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = bsc_pkg::CFG_GROUP_A;
        i_cfg_data = '0;
        cal_a = '0; cal_b = '0; cal_c = '0; cal_d = '0;
        src_idle_pct = 0; rx_stall_pct = 0;
        error_count = 0; cfg_writes = 0; quiet_cycles = 0;
        reading_taken = 1'b0;
        edge_ut = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd27898};
        edge_rp = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'd762976};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset calibration: the temperature divisor is zero for every item
        for (int k = 0; k < 5; k++) queue_reading(edge_ut[k], edge_rp[4 - k]);
        wait_drained();

        for (int ph = 1; ph < PHASES; ph++) begin
            // datasheet calibration as the base
            ga = {16'hC7D1, 16'hFFB8, 16'd408};
            gb = {16'd23153, 16'd32757, 16'd32741};
            gc = {16'd0, 16'd4, 16'd6190};
            gd = {16'd0, 16'd2868, 16'hDDF9};
            case (ph)
                2: begin
                    ga = '1; gb = '1; gc = 48'hFFFF_FFFF; gd = 48'hFFFF_FFFF;
                end
                3: begin
                    ga = {3{16'h8000}}; gb = {3{16'h8000}};
                    gc = {16'd0, {2{16'h8000}}}; gd = {16'd0, {2{16'h8000}}};
                end
                4: gb[15:0] = 16'd0;    // pressure divisor forced to zero
                5, 6: begin
                    ga = 48'({$urandom, $urandom});
                    gb = 48'({$urandom, $urandom});
                    gc = {16'd0, $urandom};
                    gd = {16'd0, $urandom};
                end
                7: begin
                    // datasheet values with small random perturbation
                    ga[15:0] = ga[15:0] + 16'($urandom_range(200)) - 16'd100;
                    gb[31:16] = gb[31:16] - 16'($urandom_range(2000));
                    gd[31:16] = gd[31:16] + 16'($urandom_range(500));
                end
                8: begin
                    ga = '0; gb = '0; gc = '0; gd = {16'd0, 16'd1, 16'd0};
                end
                default: ;
            endcase
            write_cal(bsc_pkg::CFG_GROUP_A, ga);
            write_cal(bsc_pkg::CFG_GROUP_B, gb);
            write_cal(bsc_pkg::CFG_GROUP_C, gc);
            write_cal(bsc_pkg::CFG_GROUP_D, gd);

            case (ph % 4)
                0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin src_idle_pct = 56; rx_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  rx_stall_pct = 56; end
                default: begin src_idle_pct = 8; rx_stall_pct = 8; end
            endcase

            // field extremes; full cross only for the datasheet set
            if (ph == 1) begin
                for (int i = 0; i < 5; i++)
                    for (int j = 0; j < 5; j++) queue_reading(edge_ut[i], edge_rp[j]);
            end else begin
                for (int k = 0; k < 5; k++) queue_reading(edge_ut[k], edge_rp[k]);
                queue_reading(gb[47:32], edge_rp[4]);   // first temperature term zero
            end

            // mostly plausible readings, some across the full range
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if ($urandom_range(99) < 70)
                    queue_reading(16'($urandom_range(35000, 20000)),
                                  24'($urandom_range(900000, 300000)));
                else
                    queue_reading(16'($urandom), 24'($urandom));
            end

            // a stretch with no gaps halfway through
            wait (pending_readings.size() < RANDOM_PER_PHASE / 2);
            src_idle_pct = 0;
            rx_stall_pct = 0;
            wait_drained();
        end

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
